FILE: hw/rtl/lodr_pkg.sv
package lodr_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_HAS_DST    = 3'd0,
        CFG_STD_OFFSET = 3'd1,
        CFG_DST_OFFSET = 3'd2,
        CFG_START_RULE = 3'd3,
        CFG_START_TIME = 3'd4,
        CFG_END_RULE   = 3'd5,
        CFG_END_TIME   = 3'd6
    } t_cfg_idx;

    // Rule kinds; both remaining codes select a zero-based day count.
    localparam logic [1:0] KIND_M = 2'd0;
    localparam logic [1:0] KIND_J = 2'd1;

    typedef struct packed {
        logic [8:0] dnum;
        logic [2:0] wday;
        logic [2:0] week;
        logic [3:0] month;
        logic [1:0] kind;
    } t_rule;

    localparam int CFG_W = 21;

    // Pipeline depth: nine year stages, nine lane stages, compare and output.
    localparam int NSTG    = 20;
    // Stages that the timestamp travels before the compare stage.
    localparam int UTC_DLY = 18;

    // Bias that keeps the local second count positive: 2^24 whole days.
    localparam logic [41:0] DAY_BIAS = 42'd1449551462400;
    // Removes the 2^24 day bias, adds the civil epoch shift and 64 eras.
    localparam logic [24:0] ZB_SUB   = 25'd6707540;
    localparam logic [15:0] YEAR_BIAS = 16'd25600;
    localparam logic [24:0] FIRST_SUB = 25'd10069676;
    localparam logic [25:0] MOD7_BIAS = 26'd29360128;

    // Reciprocals for exact floor division of n < 2^N by d:
    // k = N + clog2(d), m = ceil(2^k / d).
    localparam int unsigned  K_675    = 45;
    localparam logic [63:0]  M_675    = ((64'd1 << 45) + 64'd674) / 64'd675;
    localparam int unsigned  K_ERA    = 42;
    localparam logic [63:0]  M_ERA    = ((64'd1 << 42) + 64'd146096) / 64'd146097;
    localparam int unsigned  K_1460   = 29;
    localparam logic [63:0]  M_1460   = ((64'd1 << 29) + 64'd1459) / 64'd1460;
    localparam int unsigned  K_36524  = 34;
    localparam logic [63:0]  M_36524  = ((64'd1 << 34) + 64'd36523) / 64'd36524;
    localparam int unsigned  K_146096 = 36;
    localparam logic [63:0]  M_146096 = ((64'd1 << 36) + 64'd146095) / 64'd146096;
    localparam int unsigned  K_365    = 27;
    localparam logic [63:0]  M_365    = ((64'd1 << 27) + 64'd364) / 64'd365;
    localparam int unsigned  K_Y100   = 16;
    localparam logic [63:0]  M_Y100   = ((64'd1 << 16) + 64'd99) / 64'd100;
    localparam int unsigned  K_153    = 19;
    localparam logic [63:0]  M_153    = ((64'd1 << 19) + 64'd152) / 64'd153;
    localparam int unsigned  K_400    = 25;
    localparam logic [63:0]  M_400    = ((64'd1 << 25) + 64'd399) / 64'd400;
    localparam int unsigned  K_100    = 23;
    localparam logic [63:0]  M_100    = ((64'd1 << 23) + 64'd99) / 64'd100;
    localparam int unsigned  K_7      = 29;
    localparam logic [63:0]  M_7      = ((64'd1 << 29) + 64'd6) / 64'd7;

    // Day of the March-based year on which each month starts.
    localparam logic [8:0] MONTH_DOY [12] = '{
        9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
        9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
    };

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic logic [63:0] f_mulshr(input logic [63:0] n, input logic [63:0] m,
                                             input int unsigned k);
        return (n * m) >> k;
    endfunction

endpackage

FILE: hw/rtl/lodr_in_if.sv
interface lodr_in_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] utc_seconds;

    modport source (output valid, output utc_seconds, input ready);
    modport sink   (input valid, input utc_seconds, output ready);
endinterface

FILE: hw/rtl/lodr_out_if.sv
interface lodr_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] offset_seconds;
    logic               dst_active;

    modport source (output valid, output offset_seconds, output dst_active, input ready);
    modport sink   (input valid, input offset_seconds, input dst_active, output ready);
endinterface

FILE: hw/rtl/lodr_year.sv
module lodr_year (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [39:0] i_utc,
    input  logic signed [17:0] i_std_offset,
    output logic        [15:0] o_year
);

    logic [41:0] s_a;
    logic [34:0] r_x;
    logic [52:0] r_pph;
    logic [53:0] r_ppl;
    logic [71:0] s_sum;
    logic [23:0] r_zb;
    logic [23:0] r_zb4;
    logic [6:0]  r_erap4, r_erap5, r_erap6, r_erap7, r_erap8;
    logic [17:0] r_doe5, r_doe6, r_doe7;
    logic [17:0] r_t6;
    logic [8:0]  r_yoe7, r_yoe8;
    logic [8:0]  r_doy8;
    logic [17:0] n_t;
    logic [8:0]  n_doy;
    logic [3:0]  s_mp;
    logic [15:0] r_year;

    assign s_a = 42'(i_utc) + 42'(i_std_offset) + lodr_pkg::DAY_BIAS;
    assign s_sum = {1'b0, r_pph, 18'd0} + 72'(r_ppl);

    assign n_t = 18'(r_doe5
                 - 18'(lodr_pkg::f_mulshr(64'(r_doe5), lodr_pkg::M_1460, lodr_pkg::K_1460))
                 + 18'(lodr_pkg::f_mulshr(64'(r_doe5), lodr_pkg::M_36524, lodr_pkg::K_36524))
                 - 18'(lodr_pkg::f_mulshr(64'(r_doe5), lodr_pkg::M_146096,
                                          lodr_pkg::K_146096)));

    assign n_doy = 9'(r_doe7 - (18'(r_yoe7) * 18'd365 + 18'(r_yoe7 >> 2)
                   - 18'(lodr_pkg::f_mulshr(64'(r_yoe7), lodr_pkg::M_Y100,
                                            lodr_pkg::K_Y100))));

    assign s_mp = 4'(lodr_pkg::f_mulshr(64'(r_doy8) * 64'd5 + 64'd2, lodr_pkg::M_153,
                                        lodr_pkg::K_153));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= s_a[41:7];
            r_pph   <= 53'(64'(r_x[34:18]) * lodr_pkg::M_675);
            r_ppl   <= 54'(64'(r_x[17:0]) * lodr_pkg::M_675);
            r_zb    <= 24'(25'(s_sum[69:45]) - lodr_pkg::ZB_SUB);
            r_erap4 <= 7'(lodr_pkg::f_mulshr(64'(r_zb), lodr_pkg::M_ERA, lodr_pkg::K_ERA));
            r_zb4   <= r_zb;
            r_doe5  <= 18'(r_zb4 - 24'(r_erap4) * 24'd146097);
            r_erap5 <= r_erap4;
            r_t6    <= n_t;
            r_doe6  <= r_doe5;
            r_erap6 <= r_erap5;
            r_yoe7  <= 9'(lodr_pkg::f_mulshr(64'(r_t6), lodr_pkg::M_365, lodr_pkg::K_365));
            r_doe7  <= r_doe6;
            r_erap7 <= r_erap6;
            r_doy8  <= n_doy;
            r_yoe8  <= r_yoe7;
            r_erap8 <= r_erap7;
            r_year  <= 16'(r_yoe8) + 16'(r_erap8) * 16'd400 - lodr_pkg::YEAR_BIAS
                       + 16'(s_mp >= 4'd10);
        end
    end

    assign o_year = r_year;

endmodule

FILE: hw/rtl/lodr_lane.sv
module lodr_lane (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic           [15:0] i_year,
    input  lodr_pkg::t_rule       i_rule,
    input  logic signed    [20:0] i_secs,
    input  logic signed    [17:0] i_off,
    output logic signed    [43:0] o_instant
);

    logic [3:0]  s_monc, s_mm, s_mi;
    logic [2:0]  s_wday, s_week;
    logic [15:0] r_ya1, r_yb1, r_ya2, r_yb2;
    logic [8:0]  r_doym1, r_doym2, r_doym3;
    logic [6:0]  r_erap2, r_erap3, r_erap4;
    logic [9:0]  r_y100;
    logic [8:0]  r_yoe3;
    logic        r_leap3, r_leap4, r_leap5, r_leap6, r_leap7;
    logic        s_z100, n_leap;
    logic [17:0] r_doe4;
    logic [24:0] r_first5, r_first6, r_first7;
    logic [25:0] s_fb, r_fb6;
    logic [23:0] r_q7;
    logic [2:0]  s_r, r_wd7;
    logic [3:0]  s_d;
    logic [5:0]  s_dom;
    logic [5:0]  s_inm;
    logic [10:0] s_off;
    logic signed [25:0] r_day8;
    logic signed [43:0] r_inst;

    // Rule field normalization.
    always_comb begin
        if (i_rule.month == 4'd0) begin
            s_monc = 4'd1;
        end else if (i_rule.month > 4'd12) begin
            s_monc = 4'd12;
        end else begin
            s_monc = i_rule.month;
        end
        s_mm   = (i_rule.kind == lodr_pkg::KIND_M) ? s_monc : 4'd1;
        s_mi   = s_mm - 4'd1;
        s_wday = (i_rule.wday == 3'd7) ? 3'd0 : i_rule.wday;
        if (i_rule.week == 3'd0) begin
            s_week = 3'd1;
        end else if (i_rule.week > 3'd5) begin
            s_week = 3'd5;
        end else begin
            s_week = i_rule.week;
        end
    end

    assign s_z100 = (r_yb2 == 16'(r_y100) * 16'd100);
    assign n_leap = (r_yb2[1:0] == 2'd0 && !s_z100) || (s_z100 && r_y100[1:0] == 2'd0);
    assign s_fb   = {r_first5[24], r_first5} + lodr_pkg::MOD7_BIAS;
    assign s_r    = 3'(r_fb6 - 26'(r_q7) * 26'd7);

    always_comb begin
        s_d = 4'(s_wday) + 4'd7 - 4'(r_wd7);
        if (s_d >= 4'd7) begin
            s_d = s_d - 4'd7;
        end
        s_dom = 6'd1 + 6'(s_d) + 6'(s_week - 3'd1) * 6'd7;
        s_inm = 6'(lodr_pkg::MONTH_LEN[s_mi]) + 6'(s_mm == 4'd2 && r_leap7);
        if (s_dom > s_inm) begin
            s_dom = s_dom - 6'd7;
        end
        case (i_rule.kind)
            lodr_pkg::KIND_M: s_off = 11'(s_dom) - 11'd1;
            lodr_pkg::KIND_J: s_off = 11'(i_rule.dnum) - 11'd1
                                      + 11'(r_leap7 && i_rule.dnum >= 9'd60);
            default:          s_off = 11'(i_rule.dnum);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ya1    <= i_year + lodr_pkg::YEAR_BIAS - 16'(s_mm <= 4'd2);
            r_yb1    <= i_year + lodr_pkg::YEAR_BIAS;
            r_doym1  <= lodr_pkg::MONTH_DOY[s_mi];
            r_erap2  <= 7'(lodr_pkg::f_mulshr(64'(r_ya1), lodr_pkg::M_400, lodr_pkg::K_400));
            r_y100   <= 10'(lodr_pkg::f_mulshr(64'(r_yb1), lodr_pkg::M_100, lodr_pkg::K_100));
            r_ya2    <= r_ya1;
            r_yb2    <= r_yb1;
            r_doym2  <= r_doym1;
            r_yoe3   <= 9'(r_ya2 - 16'(r_erap2) * 16'd400);
            r_leap3  <= n_leap;
            r_erap3  <= r_erap2;
            r_doym3  <= r_doym2;
            r_doe4   <= 18'(r_yoe3) * 18'd365 + 18'(r_yoe3 >> 2)
                        - 18'(lodr_pkg::f_mulshr(64'(r_yoe3), lodr_pkg::M_Y100,
                                                 lodr_pkg::K_Y100))
                        + 18'(r_doym3);
            r_erap4  <= r_erap3;
            r_leap4  <= r_leap3;
            r_first5 <= 25'(r_erap4) * 25'd146097 + 25'(r_doe4) - lodr_pkg::FIRST_SUB;
            r_leap5  <= r_leap4;
            r_q7     <= 24'(lodr_pkg::f_mulshr(64'(s_fb), lodr_pkg::M_7, lodr_pkg::K_7));
            r_fb6    <= s_fb;
            r_first6 <= r_first5;
            r_leap6  <= r_leap5;
            // Weekday of the first day: 1970-01-01 was a Thursday.
            r_wd7    <= (s_r >= 3'd3) ? s_r - 3'd3 : s_r + 3'd4;
            r_first7 <= r_first6;
            r_leap7  <= r_leap6;
            r_day8   <= $signed({r_first7[24], r_first7}) + 26'(signed'(s_off));
            r_inst   <= 44'(r_day8) * 44'sd86400 + 44'(i_secs) - 44'(i_off);
        end
    end

    assign o_instant = r_inst;

endmodule

FILE: hw/rtl/local_offset_with_dst_rules.sv
// Pipeline: 20 register stages, the last of which is the output register.
// Throughput: one timestamp per cycle; the whole pipeline advances together, held
// only while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and loads the register
// reset values; data registers are not reset.
module local_offset_with_dst_rules (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [lodr_pkg::CFG_W-1:0]   i_cfg_data,
    lodr_in_if.sink                      i_in,
    lodr_out_if.source                   o_out
);

    // Stage map: stages 1 to 9 reduce the timestamp to the year of the standard
    // local date, stages 10 to 18 build the start and end instants of that
    // year in two parallel lanes, stage 19 compares, and stage 20 is the
    // output register.

    logic               r_has_dst;
    logic signed [17:0] r_std_offset;
    logic signed [17:0] r_dst_offset;
    lodr_pkg::t_rule    r_start_rule;
    logic signed [20:0] r_start_time;
    lodr_pkg::t_rule    r_end_rule;
    logic signed [20:0] r_end_time;

    logic [lodr_pkg::NSTG-1:0] r_v;
    logic               s_en;
    logic signed [39:0] r_utc [lodr_pkg::UTC_DLY];
    logic [15:0]        s_year;
    logic signed [43:0] s_start, s_end, s_utc;
    logic               r_lt_se, r_ge_s, r_lt_e;
    logic               n_dst;
    logic signed [17:0] r_out_off;
    logic               r_out_dst;

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_dst    <= 1'b0;
            r_std_offset <= 18'sd0;
            r_dst_offset <= 18'sd3600;
            r_start_rule <= lodr_pkg::t_rule'(21'd140);
            r_start_time <= 21'sd7200;
            r_end_rule   <= lodr_pkg::t_rule'(21'd108);
            r_end_time   <= 21'sd7200;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lodr_pkg::CFG_HAS_DST:    r_has_dst    <= i_cfg_data[0];
                lodr_pkg::CFG_STD_OFFSET: r_std_offset <= i_cfg_data[17:0];
                lodr_pkg::CFG_DST_OFFSET: r_dst_offset <= i_cfg_data[17:0];
                lodr_pkg::CFG_START_RULE: r_start_rule <= lodr_pkg::t_rule'(i_cfg_data);
                lodr_pkg::CFG_START_TIME: r_start_time <= i_cfg_data;
                lodr_pkg::CFG_END_RULE:   r_end_rule   <= lodr_pkg::t_rule'(i_cfg_data);
                lodr_pkg::CFG_END_TIME:   r_end_time   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign s_en       = !r_v[lodr_pkg::NSTG-1] || o_out.ready;
    assign i_in.ready = s_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (s_en) begin
            r_v <= {r_v[lodr_pkg::NSTG-2:0], i_in.valid};
        end
    end

    // The timestamp rides alongside the year and lane stages.
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_utc[0] <= i_in.utc_seconds;
            for (int i = 1; i < lodr_pkg::UTC_DLY; i++) begin
                r_utc[i] <= r_utc[i-1];
            end
        end
    end

    lodr_year u_year (
        .i_clk        (i_clk),
        .i_en         (s_en),
        .i_utc        (i_in.utc_seconds),
        .i_std_offset (r_std_offset),
        .o_year       (s_year)
    );

    // The start fires in standard time, the end in daylight time.
    lodr_lane u_start (
        .i_clk     (i_clk),
        .i_en      (s_en),
        .i_year    (s_year),
        .i_rule    (r_start_rule),
        .i_secs    (r_start_time),
        .i_off     (r_std_offset),
        .o_instant (s_start)
    );

    lodr_lane u_end (
        .i_clk     (i_clk),
        .i_en      (s_en),
        .i_year    (s_year),
        .i_rule    (r_end_rule),
        .i_secs    (r_end_time),
        .i_off     (r_dst_offset),
        .o_instant (s_end)
    );

    assign s_utc = 44'(r_utc[lodr_pkg::UTC_DLY-1]);

    // When the start is not before the end, the summer wraps over the new
    // year and daylight time holds outside the window from end to start.
    assign n_dst = r_has_dst && (r_lt_se ? (r_ge_s && r_lt_e) : (r_ge_s || r_lt_e));

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_lt_se   <= s_start < s_end;
            r_ge_s    <= s_utc >= s_start;
            r_lt_e    <= s_utc < s_end;
            r_out_off <= n_dst ? r_dst_offset : r_std_offset;
            r_out_dst <= n_dst;
        end
    end

    assign o_out.valid          = r_v[lodr_pkg::NSTG-1];
    assign o_out.offset_seconds = r_out_off;
    assign o_out.dst_active     = r_out_dst;

endmodule

FILE: hw/rtl/lodr_chk.sv
module lodr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [17:0] i_out_offset,
    input logic        i_out_dst
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_offset)
                                        && $stable(i_out_dst))
        else $error("stalled result changed");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken during output stall");

endmodule

bind local_offset_with_dst_rules lodr_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_offset (o_out.offset_seconds),
    .i_out_dst    (o_out.dst_active)
);

FILE: tb/sv/lodr_checker.sv
module lodr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    lodr_in_if          i_in,
    lodr_out_if         i_out,
    output int          o_fail_cnt,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DAY_SECS = 86400;

    typedef struct {
        logic signed [17:0] offset;
        logic               dst;
    } t_zone_answer;

    // Shadow copy of the zone registers.
    logic               zone_has_dst;
    logic signed [17:0] zone_std;
    logic signed [17:0] zone_dst;
    logic [20:0]        zone_start_rule;
    logic signed [20:0] zone_start_time;
    logic [20:0]        zone_end_rule;
    logic signed [20:0] zone_end_time;

    t_zone_answer answers_due[$];
    int           fail_cnt;

    assign o_fail_cnt = fail_cnt;

    function automatic bit leap_year(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
        return q;
    endfunction

    // Day number since 1970-01-01 of a civil date.
    function automatic longint days_of_date(longint y, int m, int d);
        longint era, yoe, doy, doe;
        if (m <= 2) y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic longint year_of_day(longint z);
        longint era, doe, yoe, doy, mp, m;
        z   = z + 719468;
        era = (z >= 0 ? z : z - 146096) / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = mp < 10 ? mp + 3 : mp - 9;
        return yoe + era * 400 + (m <= 2 ? 1 : 0);
    endfunction

    // UTC second at which a transition rule fires in year y, given the
    // offset in force just before the change. Also used by the stimulus.
    function automatic longint rule_utc(logic [20:0] rule_bits, longint secs, longint y,
                                        longint off_before);
        lodr_pkg::t_rule r;
        int     month, week, wday, dom, in_month, wd_first;
        longint first, day, dnum;
        r     = lodr_pkg::t_rule'(rule_bits);
        month = int'(r.month);
        week  = int'(r.week);
        wday  = int'(r.wday) % 7;
        dnum  = longint'(r.dnum);
        if (r.kind == lodr_pkg::KIND_M) begin
            if (month < 1) month = 1;
            if (month > 12) month = 12;
            if (week < 1) week = 1;
            if (week > 5) week = 5;
            first    = days_of_date(y, month, 1);
            wd_first = int'(((first % 7) + 11) % 7);
            dom      = 1 + (wday - wd_first + 7) % 7 + (week - 1) * 7;
            in_month = int'(lodr_pkg::MONTH_LEN[month - 1])
                       + ((month == 2 && leap_year(y)) ? 1 : 0);
            while (dom > in_month) dom -= 7;
            day = first + dom - 1;
        end else if (r.kind == lodr_pkg::KIND_J) begin
            // February 29 is never counted by a J day.
            day = days_of_date(y, 1, 1) + dnum - 1 + ((leap_year(y) && dnum >= 60) ? 1 : 0);
        end else begin
            day = days_of_date(y, 1, 1) + dnum;
        end
        return day * DAY_SECS + secs - off_before;
    endfunction

    function automatic t_zone_answer zone_answer(logic signed [39:0] utc_in);
        t_zone_answer a;
        longint utc, y, t_start, t_end;
        bit     in_dst;
        utc    = longint'(utc_in);
        in_dst = 0;
        if (zone_has_dst) begin
            y       = year_of_day(floor_div(utc + longint'(zone_std), DAY_SECS));
            t_start = rule_utc(zone_start_rule, longint'(zone_start_time), y,
                               longint'(zone_std));
            t_end   = rule_utc(zone_end_rule, longint'(zone_end_time), y,
                               longint'(zone_dst));
            // A start at or after the end means summer wraps over the new year.
            if (t_start < t_end) in_dst = (utc >= t_start) && (utc < t_end);
            else                 in_dst = !((utc >= t_end) && (utc < t_start));
        end
        a.offset = in_dst ? zone_dst : zone_std;
        a.dst    = in_dst;
        return a;
    endfunction

    task automatic report(string what);
        $display("ERROR at %0t: %s", $realtime, what);
        fail_cnt++;
    endtask

    initial fail_cnt = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_zone_answer want;
        if (!i_rst_n) begin
            zone_has_dst    <= 1'b0;
            zone_std        <= 18'sd0;
            zone_dst        <= 18'sd3600;
            zone_start_rule <= 21'd140;
            zone_start_time <= 21'sd7200;
            zone_end_rule   <= 21'd108;
            zone_end_time   <= 21'sd7200;
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (lodr_pkg::t_cfg_idx'(i_cfg_idx))
                    lodr_pkg::CFG_HAS_DST:    zone_has_dst    <= i_cfg_data[0];
                    lodr_pkg::CFG_STD_OFFSET: zone_std        <= i_cfg_data[17:0];
                    lodr_pkg::CFG_DST_OFFSET: zone_dst        <= i_cfg_data[17:0];
                    lodr_pkg::CFG_START_RULE: zone_start_rule <= i_cfg_data;
                    lodr_pkg::CFG_START_TIME: zone_start_time <= i_cfg_data;
                    lodr_pkg::CFG_END_RULE:   zone_end_rule   <= i_cfg_data;
                    lodr_pkg::CFG_END_TIME:   zone_end_time   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) answers_due.push_back(zone_answer(i_in.utc_seconds));
            if (i_out.valid && i_out.ready) begin
                if (answers_due.size() == 0) begin
                    report("result with no timestamp pending");
                end else begin
                    want = answers_due.pop_front();
                    if (i_out.offset_seconds !== want.offset)
                        report($sformatf("offset_seconds %0d, expected %0d",
                                         i_out.offset_seconds, want.offset));
                    if (i_out.dst_active !== want.dst)
                        report($sformatf("dst_active %b, expected %b",
                                         i_out.dst_active, want.dst));
                end
            end
        end
        o_pending <= answers_due.size();
    end
endmodule

FILE: tb/sv/tb_local_offset_with_dst_rules.sv
module tb_local_offset_with_dst_rules;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [20:0] cfg_data;
    int          fail_cnt;
    int          pending;

    lodr_in_if  in_ch ();
    lodr_out_if out_ch ();

    local_offset_with_dst_rules u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    // The checker sits beside the block, mirrors the zone registers from the
    // write port and scores every result transfer against its own prediction.
    lodr_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_fail_cnt(fail_cnt),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // The zone as last written, so that the stimulus can aim at transitions.
    logic [20:0]        zone_start_rule;
    logic signed [20:0] zone_start_time;
    logic [20:0]        zone_end_rule;
    logic signed [20:0] zone_end_time;
    logic signed [17:0] zone_std;
    logic signed [17:0] zone_dst;

    bit quiet;      // When set, neither side inserts idle cycles.
    bit hold_req;   // Asks the receiver for one long hold-off.

    function automatic logic [20:0] pack_rule(int kind, int month, int week, int wday,
                                              int dnum);
        lodr_pkg::t_rule r;
        r.kind  = kind[1:0];
        r.month = month[3:0];
        r.week  = week[2:0];
        r.wday  = wday[2:0];
        r.dnum  = dnum[8:0];
        return r;
    endfunction

    task automatic write_reg(lodr_pkg::t_cfg_idx idx, logic [20:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Waits until every pending result has come out and the pipeline has
    // drained, then loads a complete zone.
    task automatic load_zone(bit has_dst, int std_ofs, int dst_ofs, logic [20:0] s_rule,
                             int s_time, logic [20:0] e_rule, int e_time);
        while (pending != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
        zone_std        = 18'(std_ofs);
        zone_dst        = 18'(dst_ofs);
        zone_start_rule = s_rule;
        zone_start_time = 21'(s_time);
        zone_end_rule   = e_rule;
        zone_end_time   = 21'(e_time);
        write_reg(lodr_pkg::CFG_HAS_DST, {20'd0, has_dst});
        write_reg(lodr_pkg::CFG_STD_OFFSET, 21'(std_ofs));
        write_reg(lodr_pkg::CFG_DST_OFFSET, 21'(dst_ofs));
        write_reg(lodr_pkg::CFG_START_RULE, s_rule);
        write_reg(lodr_pkg::CFG_START_TIME, 21'(s_time));
        write_reg(lodr_pkg::CFG_END_RULE, e_rule);
        write_reg(lodr_pkg::CFG_END_TIME, 21'(e_time));
    endtask

    // One timestamp transfer; the valid stays up until the block takes it.
    task automatic send_utc(longint utc);
        in_ch.utc_seconds = utc[39:0];
        in_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 17) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b0;
    endtask

    // A transition instant of the current zone in some year, give or take
    // a couple of seconds.
    function automatic longint near_edge(longint y);
        longint t;
        if ($urandom_range(1))
            t = u_chk.rule_utc(zone_start_rule, longint'(zone_start_time), y,
                               longint'(zone_std));
        else
            t = u_chk.rule_utc(zone_end_rule, longint'(zone_end_time), y,
                               longint'(zone_dst));
        return t + longint'($urandom_range(4)) - 2;
    endfunction

    function automatic longint random_utc();
        int     pick;
        longint y;
        pick = $urandom_range(99);
        if (pick < 45) begin
            y = (pick < 5) ? longint'($urandom_range(40000)) - 20000
                           : longint'($urandom_range(1800, 2200));
            return near_edge(y);
        end else if (pick < 80) begin
            return longint'($urandom_range(300 * 366)) * 86400 - longint'(130 * 365) * 86400
                   + longint'($urandom_range(86399));
        end
        return longint'({$urandom, $urandom}) <<< 24 >>> 24;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_utc(random_utc());
    endtask

    // The receiver takes results at random, apart from one long hold-off
    // during which the sender keeps offering and the pipeline backs up.
    initial begin
        int held;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (held = 0; held < 80; held++) begin
                    out_ch.ready = 1'b0;
                    @(negedge i_clk);
                end
            end
            out_ch.ready = quiet ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        longint y;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = lodr_pkg::CFG_HAS_DST;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.utc_seconds = '0;
        quiet             = 1'b0;
        hold_req          = 1'b0;
        // Reset values of the zone, as the block loads them.
        zone_std        = 18'sd0;
        zone_dst        = 18'sd3600;
        zone_start_rule = 21'd140;
        zone_start_time = 21'sd7200;
        zone_end_rule   = 21'd108;
        zone_end_time   = 21'sd7200;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset zone has no daylight saving, so every answer is standard time.
        send_utc(-(longint'(1) <<< 39));
        send_utc((longint'(1) <<< 39) - 1);
        send_utc(0);
        send_utc(-1);
        send_random(60);

        // A northern zone with the usual second-Sunday / first-Sunday rules.
        load_zone(1, -18000, -14400, pack_rule(0, 3, 2, 0, 0), 7200,
                  pack_rule(0, 11, 1, 0, 0), 7200);
        send_utc(-(longint'(1) <<< 39));
        send_utc((longint'(1) <<< 39) - 1);
        send_utc(0);
        for (y = 2023; y <= 2025; y++) begin
            send_utc(u_chk.rule_utc(zone_start_rule, longint'(zone_start_time), y,
                                    longint'(zone_std)) - 1);
            send_utc(u_chk.rule_utc(zone_start_rule, longint'(zone_start_time), y,
                                    longint'(zone_std)));
            send_utc(u_chk.rule_utc(zone_end_rule, longint'(zone_end_time), y,
                                    longint'(zone_dst)) - 1);
            send_utc(u_chk.rule_utc(zone_end_rule, longint'(zone_end_time), y,
                                    longint'(zone_dst)));
        end
        hold_req = 1'b1;
        send_random(140);

        // Southern zone: the summer straddles the new year; a last-week start rule.
        load_zone(1, 36000, 39600, pack_rule(0, 10, 5, 0, 0), 7200,
                  pack_rule(0, 4, 1, 0, 0), 10800);
        quiet = 1'b1;
        send_random(150);
        quiet = 1'b0;

        // J days around February 29, including day 0; the first zone has a D day end.
        load_zone(1, 3600, 7200, pack_rule(1, 0, 0, 0, 60), 0,
                  pack_rule(2, 0, 0, 0, 300), 3600);
        send_random(120);
        load_zone(1, 0, 3600, pack_rule(1, 0, 0, 0, 0), 0,
                  pack_rule(1, 0, 0, 0, 365), 86399);
        send_random(100);

        // Out-of-range rule fields: kind 3, month 0 and 15, week 0 and 7,
        // weekday 7, a day past the end of the year.
        load_zone(1, -3600, 0, pack_rule(3, 0, 0, 7, 511), -604799,
                  pack_rule(0, 15, 7, 7, 0), 604799);
        send_random(120);
        load_zone(1, 89999, -93599, pack_rule(0, 0, 0, 7, 0), 604799,
                  pack_rule(0, 2, 6, 3, 0), -604799);
        send_random(120);
        load_zone(1, -89999, 93599, pack_rule(0, 2, 5, 6, 0), 0,
                  pack_rule(2, 0, 0, 0, 0), -1);
        send_random(120);

        // Equal rules: daylight saving holds but for the hour from end to start.
        load_zone(1, 3600, 7200, pack_rule(0, 3, 5, 0, 0), 3600,
                  pack_rule(0, 3, 5, 0, 0), 3600);
        send_random(80);

        // Random zones, and finally daylight saving switched off again.
        repeat (3) begin
            load_zone(1, int'($urandom_range(179998)) - 89999,
                      int'($urandom_range(187198)) - 93599,
                      21'($urandom), int'($urandom_range(1209598)) - 604799,
                      21'($urandom), int'($urandom_range(1209598)) - 604799);
            send_random(60);
        end
        load_zone(0, 19800, 23400, pack_rule(0, 3, 2, 0, 0), 7200,
                  pack_rule(0, 11, 1, 0, 0), 7200);
        send_random(60);

        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: local_offset_with_dst_rules.f
hw/rtl/lodr_pkg.sv
hw/rtl/lodr_in_if.sv
hw/rtl/lodr_out_if.sv
hw/rtl/lodr_year.sv
hw/rtl/lodr_lane.sv
hw/rtl/local_offset_with_dst_rules.sv
hw/rtl/lodr_chk.sv
tb/sv/lodr_checker.sv
tb/sv/tb_local_offset_with_dst_rules.sv
